// File: hw/rtl/x86_64_instruction_encoder_defines.svh
// ----------------------------------------------------------------------------
// x86-64 instruction encoder assertion macros
// Shared property forms for the checker of the encoder's ports.
// ----------------------------------------------------------------------------
`ifndef X86_64_INSTRUCTION_ENCODER_DEFINES_SVH
`define X86_64_INSTRUCTION_ENCODER_DEFINES_SVH

// Antecedent and consequent hold in the same cycle.
`define XENC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define XENC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/xenc_pkg.sv
// ----------------------------------------------------------------------------
// xenc_pkg
// Types, opcode constants and register mapping for the instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xenc_pkg;

  localparam int MaxBytes = 10;

  typedef enum logic [2:0] {
    FN_MOV_IMM = 3'd0,
    FN_ADD     = 3'd1,
    FN_SUB     = 3'd2,
    FN_IMUL    = 3'd3,
    FN_IDIV    = 3'd4,
    FN_RETQ    = 3'd5,
    FN_CQTO    = 3'd6
  } func_t;

  localparam logic [7:0] REX_W      = 8'h48;
  localparam logic [7:0] REX_B      = 8'h41;
  localparam logic [7:0] OPC_ADD    = 8'h01;
  localparam logic [7:0] OPC_SUB    = 8'h29;
  localparam logic [7:0] OPC_ESC    = 8'h0f;
  localparam logic [7:0] OPC_IMUL   = 8'haf;
  localparam logic [7:0] OPC_GRP3   = 8'hf7;
  localparam logic [7:0] OPC_RET    = 8'hc3;
  localparam logic [7:0] OPC_CQO    = 8'h99;
  localparam logic [7:0] MODRM_REG  = 8'hc0;
  localparam logic [7:0] MODRM_IDIV = 8'hf8;
  localparam logic [7:0] OPC_MOV    = 8'hb8;

  // Encoded instruction: byte 0 goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
  } enc_item_t;

  // Register file order rax,rbx,rcx,rdx,rsi,rdi,rbp,rsp to hardware codes.
  function automatic logic [2:0] hw_code(input logic [3:0] r);
    logic [2:0] c;
    if (r[3]) begin
      c = r[2:0];
    end else begin
      case (r[2:0])
        3'd0:    c = 3'd0;
        3'd1:    c = 3'd3;
        3'd2:    c = 3'd1;
        3'd3:    c = 3'd2;
        3'd4:    c = 3'd6;
        3'd5:    c = 3'd7;
        3'd6:    c = 3'd5;
        default: c = 3'd4;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/xenc_encode.sv
// ----------------------------------------------------------------------------
// xenc_encode
// Combinational encoder from one registered request to its machine code bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module xenc_encode
  import xenc_pkg::*;
(
  input  wire logic [2:0]  func,
  input  wire logic [3:0]  first_reg,
  input  wire logic [3:0]  second_reg,
  input  wire logic [63:0] immediate,
  output enc_item_t        item
);

  logic [2:0] hw_a;
  logic [2:0] hw_b;
  func_t      fn;

  assign hw_a = hw_code(first_reg);
  assign hw_b = hw_code(second_reg);
  assign fn   = func_t'(func);

  always_comb begin
    item = '0;
    unique case (fn) inside
      FN_MOV_IMM: begin
        if (immediate[63:32] == 32'h0) begin
          if (first_reg[3]) begin
            item.bytes[0]   = REX_B;
            item.bytes[1]   = OPC_MOV | {5'b0, hw_a};
            item.bytes[5:2] = immediate[31:0];
            item.len        = 4'd6;
          end else begin
            item.bytes[0]   = OPC_MOV | {5'b0, hw_a};
            item.bytes[4:1] = immediate[31:0];
            item.len        = 4'd5;
          end
        end else begin
          item.bytes[0]   = REX_W | {7'b0, first_reg[3]};
          item.bytes[1]   = OPC_MOV | {5'b0, hw_a};
          item.bytes[9:2] = immediate;
          item.len        = 4'd10;
        end
      end
      FN_ADD, FN_SUB: begin
        item.bytes[0] = REX_W | {5'b0, second_reg[3], 1'b0, first_reg[3]};
        item.bytes[1] = (fn == FN_ADD) ? OPC_ADD : OPC_SUB;
        item.bytes[2] = MODRM_REG | {2'b0, hw_b, hw_a};
        item.len      = 4'd3;
      end
      FN_IMUL: begin
        item.bytes[0] = REX_W | {5'b0, first_reg[3], 1'b0, second_reg[3]};
        item.bytes[1] = OPC_ESC;
        item.bytes[2] = OPC_IMUL;
        item.bytes[3] = MODRM_REG | {2'b0, hw_a, hw_b};
        item.len      = 4'd4;
      end
      FN_IDIV: begin
        item.bytes[0] = REX_W | {7'b0, first_reg[3]};
        item.bytes[1] = OPC_GRP3;
        item.bytes[2] = MODRM_IDIV | {5'b0, hw_a};
        item.len      = 4'd3;
      end
      FN_RETQ: begin
        item.bytes[0] = OPC_RET;
        item.len      = 4'd1;
      end
      FN_CQTO: begin
        item.bytes[0] = REX_W;
        item.bytes[1] = OPC_CQO;
        item.len      = 4'd2;
      end
      default: begin
        // Unused operation code: no bytes.
        item = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/xenc_serializer.sv
// ----------------------------------------------------------------------------
// xenc_serializer
// Output shift register that sends one encoded byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xenc_serializer
  import xenc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire enc_item_t  item,
  output logic            take,
  output logic            out_valid,
  output logic [7:0]      out_code_byte,
  output logic            out_last_byte
);

  logic [MaxBytes-1:0][7:0] buf_r;
  logic [MaxBytes-1:0][7:0] buf_nxt;
  logic [3:0]               cnt_r;
  logic [3:0]               cnt_nxt;

  // A new item loads when the register is empty or shows its last byte.
  assign take = (cnt_r <= 4'd1);

  always_comb begin
    buf_nxt = {8'h00, buf_r[MaxBytes-1:1]};
    cnt_nxt = (cnt_r != 4'd0) ? cnt_r - 4'd1 : 4'd0;
    if (take && item_valid) begin
      buf_nxt = item.bytes;
      cnt_nxt = item.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_valid     = (cnt_r != 4'd0);
  assign out_code_byte = buf_r[0];
  assign out_last_byte = (cnt_r == 4'd1);

endmodule

`default_nettype wire

// File: hw/rtl/x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder
// Encodes mov imm, add, sub, imul, idiv, retq and cqto into x86-64 bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   input     start / busy         in_func, in_first_reg, in_second_reg,
//                                  in_immediate
//   result    out_valid (strobe)   out_code_byte, out_last_byte
//
// An instruction of n bytes (1 to 10) goes out on the result port one byte
// per cycle from the output shift register; that register sets the rate.
// With the shift register free, a request goes through the input register and
// then the shift register to reach the result port, and the next instruction's
// first byte follows the previous last byte without a gap.
// Reset (rst_n low at a clock edge) empties both stages; busy drops with it.
// The receiver cannot stall; busy is high only while a request waits in the
// input register behind a shift register that still has two or more bytes.
// An unused operation code is accepted and produces no result.
`default_nettype none

module x86_64_instruction_encoder
  import xenc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic [3:0]  in_first_reg,
  input  wire logic [3:0]  in_second_reg,
  input  wire logic [63:0] in_immediate,
  output logic             out_valid,
  output logic [7:0]       out_code_byte,
  output logic             out_last_byte
);

  // Input register: holds one request until the shift register takes it.
  logic        req_valid_r;
  logic        req_valid_nxt;
  logic [2:0]  func_r;
  logic [3:0]  first_reg_r;
  logic [3:0]  second_reg_r;
  logic [63:0] immediate_r;

  logic        accept;
  logic        take;
  enc_item_t   item;

  assign busy   = req_valid_r && !take;
  assign accept = start && !busy;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (accept) begin
      req_valid_nxt = 1'b1;
    end else if (take) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  // Payload registers need no reset; they load on every accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_func;
      first_reg_r  <= in_first_reg;
      second_reg_r <= in_second_reg;
      immediate_r  <= in_immediate;
    end
  end

  // Single-pass encoding between the input register and the shift register.
  xenc_encode u_encode (
    .func       (func_r),
    .first_reg  (first_reg_r),
    .second_reg (second_reg_r),
    .immediate  (immediate_r),
    .item       (item)
  );

  xenc_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (req_valid_r),
    .item          (item),
    .take          (take),
    .out_valid     (out_valid),
    .out_code_byte (out_code_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire

// File: hw/rtl/xenc_checker.sv
// ----------------------------------------------------------------------------
// xenc_checker
// Port-level checks of the instruction encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "x86_64_instruction_encoder_defines.svh"

module xenc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last_byte
);

  // The last-byte mark only comes with a strobe.
  `XENC_ASSERT_SAME(a_last_has_strobe, clk, rst_n, out_last_byte, out_valid, "last no strobe")

  // Busy means the result port is still sending an earlier instruction.
  `XENC_ASSERT_SAME(a_busy_while_sending, clk, rst_n, busy, out_valid, "busy while idle")

  // An instruction never breaks off before its last byte.
  `XENC_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && !out_last_byte, out_valid, "gap in bytes")

  // While the last byte of an instruction shows, the block can take a new one.
  `XENC_ASSERT_SAME(a_free_on_last, clk, rst_n, out_last_byte, !busy, "busy on last byte")

endmodule

bind x86_64_instruction_encoder xenc_checker u_xenc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_last_byte (out_last_byte)
);

`default_nettype wire

// File: tb/tb_x86_64_instruction_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_64_instruction_encoder
// Self-checking bench for the x86-64 instruction encoder. A directed list of
// corner-case instructions runs first, then several hundred random ones. Each
// accepted request is encoded by an in-bench model into a byte stream, and
// every byte strobed out of the encoder is compared against it in order.
// ----------------------------------------------------------------------------

module tb_x86_64_instruction_encoder;
  import xenc_pkg::*;

  // Operation code 7 has no meaning: the encoder takes it and emits nothing.
  localparam logic [2:0] FnUnused = 3'd7;

  // Hardware register codes for rax,rbx,rcx,rdx,rsi,rdi,rbp,rsp, three bits
  // each, with rax in the least significant slot.
  localparam logic [23:0] LowRegCodes =
    {3'd4, 3'd5, 3'd7, 3'd6, 3'd2, 3'd1, 3'd3, 3'd0};

  localparam int RandomCount = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 200000;
  localparam int MaxReported = 10;

  // One instruction request as presented on the input ports.
  typedef struct {
    logic [2:0]  func;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [63:0] immediate;
  } request_t;

  // One byte of machine code together with its end-of-instruction mark.
  typedef struct {
    logic [7:0] code;
    logic       last;
  } code_byte_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic [2:0]  in_func       = 3'd0;
  logic [3:0]  in_first_reg  = 4'd0;
  logic [3:0]  in_second_reg = 4'd0;
  logic [63:0] in_immediate  = 64'd0;
  logic        busy;
  logic        out_valid;
  logic [7:0]  out_code_byte;
  logic        out_last_byte;

  // Requests waiting to be driven, and the bytes the encoder still owes us.
  request_t   pending_requests[$];
  code_byte_t owed_bytes[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int idle_left      = 0;
  int accepted_count = 0;

  x86_64_instruction_encoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_first_reg  (in_first_reg),
    .in_second_reg (in_second_reg),
    .in_immediate  (in_immediate),
    .out_valid     (out_valid),
    .out_code_byte (out_code_byte),
    .out_last_byte (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Encoding model
  // ------------------------------------------------------------------------

  // Three-bit register code as it appears in the opcode or ModRM byte. The
  // upper half of the register file maps straight through; bit 3 goes to REX.
  function automatic logic [2:0] reg_field(input logic [3:0] r);
    if (r[3]) begin
      return r[2:0];
    end
    return LowRegCodes[r[2:0]*3 +: 3];
  endfunction

  // Works out the byte stream for one accepted request and appends it to the
  // list of owed bytes. An unused operation code appends nothing.
  task automatic encode_request(input request_t rq);
    logic [7:0] enc[10];
    int         n;
    logic [2:0] a_code;
    logic [2:0] b_code;
    n      = 0;
    a_code = reg_field(rq.first_reg);
    b_code = reg_field(rq.second_reg);
    case (rq.func) inside
      FN_MOV_IMM: begin
        // A constant that fits in 32 unsigned bits uses the zero-extending
        // form, which needs a prefix only to reach r8..r15.
        if (rq.immediate[63:32] == 32'd0) begin
          if (rq.first_reg[3]) begin
            enc[n] = REX_B;
            n++;
          end
          enc[n] = OPC_MOV | {5'd0, a_code};
          n++;
          for (int i = 0; i < 4; i++) begin
            enc[n] = rq.immediate[8*i +: 8];
            n++;
          end
        end else begin
          enc[n] = REX_W | {7'd0, rq.first_reg[3]};
          n++;
          enc[n] = OPC_MOV | {5'd0, a_code};
          n++;
          for (int i = 0; i < 8; i++) begin
            enc[n] = rq.immediate[8*i +: 8];
            n++;
          end
        end
      end
      FN_ADD, FN_SUB: begin
        // Source in ModRM.reg (REX.R), destination in ModRM.rm (REX.B).
        enc[0] = REX_W | {5'd0, rq.second_reg[3], 1'b0, rq.first_reg[3]};
        enc[1] = (rq.func == FN_ADD) ? OPC_ADD : OPC_SUB;
        enc[2] = MODRM_REG | {2'd0, b_code, a_code};
        n = 3;
      end
      FN_IMUL: begin
        // The two-byte opcode swaps the roles: destination in ModRM.reg.
        enc[0] = REX_W | {5'd0, rq.first_reg[3], 1'b0, rq.second_reg[3]};
        enc[1] = OPC_ESC;
        enc[2] = OPC_IMUL;
        enc[3] = MODRM_REG | {2'd0, a_code, b_code};
        n = 4;
      end
      FN_IDIV: begin
        enc[0] = REX_W | {7'd0, rq.first_reg[3]};
        enc[1] = OPC_GRP3;
        enc[2] = MODRM_IDIV | {5'd0, a_code};
        n = 3;
      end
      FN_RETQ: begin
        enc[0] = OPC_RET;
        n = 1;
      end
      FN_CQTO: begin
        enc[0] = REX_W;
        enc[1] = OPC_CQO;
        n = 2;
      end
      default: begin
        n = 0;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      owed_bytes.push_back('{code: enc[i], last: (i == n - 1)});
    end
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  task automatic queue_request(input logic [2:0] func, input logic [3:0] ra,
                               input logic [3:0] rb, input logic [63:0] imm);
    pending_requests.push_back('{func: func, first_reg: ra, second_reg: rb,
                                 immediate: imm});
  endtask

  // Idle time before the next transaction. The bench alternates between
  // stretches of 40 back-to-back transactions and stretches with gaps, so
  // the encoder sees both a full pipeline and starts landing at every point
  // of a byte stream. Gaps are mostly short, now and then long.
  function automatic int pick_gap();
    int roll;
    if ((accepted_count / 40) % 2 == 0) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Random constant for mov: an even mix of the short form, short values up to
  // 255, the full 64-bit form, and long-form values with one upper-half bit set.
  function automatic logic [63:0] pick_immediate();
    case ($urandom_range(0, 3))
      0:       return {32'd0, 32'($urandom)};
      1:       return {32'($urandom), 32'($urandom)};
      2:       return {32'd0, 32'($urandom_range(0, 255))};
      default: return {32'd1 << $urandom_range(0, 31), 32'($urandom)};
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Driver
  // ------------------------------------------------------------------------
  // A transaction completes at an edge where start is high and busy is low.
  // Each input gets at most one nonblocking assignment per edge: while a
  // request is held against busy nothing is assigned, so start stays high.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        encode_request(pending_requests[0]);
        void'(pending_requests.pop_front());
        accepted_count++;
        idle_left = pick_gap();
      end
      if (start && busy) begin
        // Hold the current request until the encoder can take it.
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        start         <= 1'b1;
        in_func       <= pending_requests[0].func;
        in_first_reg  <= pending_requests[0].first_reg;
        in_second_reg <= pending_requests[0].second_reg;
        in_immediate  <= pending_requests[0].immediate;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor
  // ------------------------------------------------------------------------
  // The receiver cannot stall, so every strobed byte is taken at the edge
  // that ends its cycle and checked against the oldest owed byte.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("ERROR: unexpected byte %02h last=%0b with nothing owed",
                   out_code_byte, out_last_byte);
        end
      end else begin
        if (out_code_byte !== owed_bytes[0].code ||
            out_last_byte !== owed_bytes[0].last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("ERROR: byte exp %02h last=%0b, got %02h last=%0b",
                     owed_bytes[0].code, owed_bytes[0].last,
                     out_code_byte, out_last_byte);
          end
        end
        void'(owed_bytes.pop_front());
      end
    end
  end

  // Watchdog: a hung handshake or a missing byte ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    int       produced;
    logic [2:0] func;
    int       roll;

    // Directed corners: both mov forms at their boundaries, the REX bits of
    // every operation from both halves of the register file, the imul case
    // where the source is exactly r8, operand fields that must be ignored,
    // and the unused operation code.
    queue_request(FN_MOV_IMM, 4'd0,  4'd0,  64'h0000_0000_0000_0000);
    queue_request(FN_MOV_IMM, 4'd15, 4'd0,  64'h0000_0000_FFFF_FFFF);
    queue_request(FN_MOV_IMM, 4'd8,  4'd5,  64'h0000_0001_0000_0000);
    queue_request(FN_MOV_IMM, 4'd7,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(FN_MOV_IMM, 4'd15, 4'd15, 64'h8000_0000_0000_0000);
    queue_request(FN_MOV_IMM, 4'd1,  4'd0,  64'h7FFF_FFFF_FFFF_FFFF);
    queue_request(FN_ADD,     4'd0,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(FN_ADD,     4'd15, 4'd0,  64'd0);
    queue_request(FN_ADD,     4'd3,  4'd6,  64'd0);
    queue_request(FN_SUB,     4'd7,  4'd8,  64'd0);
    queue_request(FN_SUB,     4'd15, 4'd15, 64'd0);
    queue_request(FN_SUB,     4'd2,  4'd4,  64'd0);
    queue_request(FN_IMUL,    4'd0,  4'd15, 64'd0);
    queue_request(FN_IMUL,    4'd15, 4'd0,  64'd0);
    queue_request(FN_IMUL,    4'd7,  4'd8,  64'd0);
    queue_request(FN_IMUL,    4'd8,  4'd7,  64'd0);
    queue_request(FN_IDIV,    4'd0,  4'd9,  64'd0);
    queue_request(FN_IDIV,    4'd15, 4'd0,  64'd0);
    queue_request(FN_IDIV,    4'd5,  4'd0,  64'd0);
    queue_request(FN_RETQ,    4'd0,  4'd0,  64'd0);
    queue_request(FN_RETQ,    4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(FN_CQTO,    4'd0,  4'd0,  64'd0);
    queue_request(FN_CQTO,    4'd9,  4'd6,  64'hA5A5_5A5A_0000_FFFF);
    queue_request(FnUnused,   4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(FN_RETQ,    4'd4,  4'd11, 64'd0);

    // Random instructions. mov gets extra weight since it has the most
    // cases; a few unused codes are mixed in but do not count.
    produced = 0;
    while (produced < RandomCount) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        func = FnUnused;
      end else if (roll < 34) begin
        func = FN_MOV_IMM;
      end else begin
        func = 3'($urandom_range(1, 6));
      end
      queue_request(func, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    pick_immediate());
      if (func != FnUnused) begin
        produced++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every owed byte to come out, then
    // give the encoder some time to show any stray bytes.
    while (pending_requests.size() > 0 || owed_bytes.size() > 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
